// File: src/wlps_pkg.sv
// Shared types and constants for the windowed local peak search block.
package wlps_pkg;

    // Input request kinds carried on s_tuser.
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] CFG_FORWARD     = 2'd1;
    localparam logic [1:0] CFG_MINIMUM     = 2'd2;

    localparam int WIN_W    = 8;
    localparam int HALF_W   = 7;
    localparam int HALF_MAX = 127;
    localparam int NCELL    = 2 * HALF_MAX + 1;
    localparam int POS_W    = 12;

    typedef struct packed {
        logic              shift;
        logic              clear;
        logic              find_min;
        logic [HALF_W-1:0] half;
    } cell_ctrl_t;

endpackage

// File: src/wlps_cell.sv
// One window cell: holds a sample, passes it on, and flags a sample that beats the centre.
module wlps_cell
    import wlps_pkg::*;
#(
    parameter int IDX = 0,
    parameter int SW  = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cell_ctrl_t    ctrl,
    input  logic [SW-1:0] prev_data,
    input  logic          prev_valid,
    input  logic [SW-1:0] cen_val,
    output logic [SW-1:0] data_o,
    output logic          valid_o,
    output logic          fail_o
);

    logic [SW-1:0] data_reg;
    logic          valid_reg;
    logic          fail_reg;
    logic          in_win;
    logic          beats;

    localparam logic [WIN_W-1:0] MY_IDX = WIN_W'(IDX);

    // The window covers cells 0 .. 2*half; the centre sits at cell half.
    assign in_win = (MY_IDX <= {ctrl.half, 1'b0}) && (MY_IDX != {1'b0, ctrl.half});
    assign beats  = ctrl.find_min ? ($signed(data_reg) < $signed(cen_val))
                                  : ($signed(data_reg) > $signed(cen_val));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            fail_reg  <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                valid_reg <= 1'b0;
            end else if (ctrl.shift) begin
                valid_reg <= prev_valid;
            end
            fail_reg <= valid_reg && in_win && beats;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            data_reg <= prev_data;
        end
    end

    assign data_o  = data_reg;
    assign valid_o = valid_reg;
    assign fail_o  = fail_reg;

endmodule

// File: src/windowed_local_peak_search.sv
// Top level of the windowed local peak search: sample store, window cell chain, search control.
// Appends and clears complete in the idle state. A search stalls the input while it runs: the
// window of 2*half+1 samples is streamed from the sample memory's read port into a chain of
// cells, one sample per cycle, then each centre position is handled in order (shift in one
// sample, latch the centre, compare in every cell, reduce and decide), and the search ends in
// a result state that waits until the output can take the result. A search whose first
// window already reaches past the stored data goes straight to the result state.
// s_tuser carries the request kind; found is returned on m_tuser.
module windowed_local_peak_search
    import wlps_pkg::*;
#(
    parameter int STORE_DEPTH  = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample[SAMPLE_WIDTH-1:0], start_position[SAMPLE_WIDTH+11:SAMPLE_WIDTH], zero fill
    input  logic [((SAMPLE_WIDTH+POS_W+7)/8)*8-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // peak_index[11:0], peak_value[SAMPLE_WIDTH+11:12], zero fill
    output logic [((SAMPLE_WIDTH+POS_W+7)/8)*8-1:0] m_tdata,
    // found[0]
    output logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [WIN_W-1:0]     cfg_data
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int PW     = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 2;
    localparam int DATA_W = ((SAMPLE_WIDTH + POS_W + 7) / 8) * 8;
    localparam logic signed [PW-1:0] STEP = PW'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SETTLE = 3'd2;
    localparam logic [2:0] S_CEN    = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_DEC    = 3'd5;
    localparam logic [2:0] S_RES    = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WIN_W-1:0]   win_size_reg;
    logic               fwd_reg, min_reg;
    logic [HALF_W-1:0]  half_reg, half_next;
    logic [WIN_W-1:0]   left_reg, left_next;
    logic signed [PW-1:0] rd_pos_reg, rd_pos_next;
    logic signed [PW-1:0] centre_reg, centre_next;
    logic               rd_en_reg, rd_en_next;
    logic               clear_next;
    logic [SW-1:0]      rd_data_reg;
    logic [SW-1:0]      cen_val_reg;
    logic               res_found_reg, res_found_next;
    logic [POS_W-1:0]   res_idx_reg, res_idx_next;
    logic [SW-1:0]      res_val_reg, res_val_next;
    logic               m_valid_reg;
    logic               m_found_reg;
    logic [POS_W-1:0]   m_idx_reg;
    logic [SW-1:0]      m_val_reg;

    logic [SW-1:0]      mem [STORE_DEPTH];

    logic [1:0]         in_op;
    logic [SW-1:0]      in_sample;
    logic [POS_W-1:0]   in_start;
    logic               in_acc;
    logic               wr_en;
    logic               out_load;
    logic [HALF_W-1:0]  in_half;
    logic signed [PW-1:0] start_s, half_in_s, half_s, count_s;
    logic               peak;

    cell_ctrl_t         ctrl;
    logic [SW-1:0]      cell_data  [NCELL];
    logic               cell_valid [NCELL];
    logic [NCELL-1:0]   cell_fail;

    assign in_op     = s_tuser;
    assign in_sample = s_tdata[SW-1:0];
    assign in_start  = s_tdata[SW+POS_W-1:SW];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign wr_en     = in_acc && (in_op == OP_APPEND) && (count_reg < CNT_W'(STORE_DEPTH));
    assign in_half   = win_size_reg[WIN_W-1:1];

    assign start_s   = signed'({{(PW-POS_W){1'b0}}, in_start});
    assign half_in_s = signed'({{(PW-HALF_W){1'b0}}, in_half});
    assign half_s    = signed'({{(PW-HALF_W){1'b0}}, half_reg});
    assign count_s   = signed'({{(PW-CNT_W){1'b0}}, count_reg});
    assign peak      = ~|cell_fail;
    assign out_load  = (state_reg == S_RES) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        half_next      = half_reg;
        left_next      = left_reg;
        rd_pos_next    = rd_pos_reg;
        centre_next    = centre_reg;
        rd_en_next     = 1'b0;
        clear_next     = 1'b0;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        res_val_next   = res_val_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_APPEND: begin
                            if (wr_en) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_SEARCH: begin
                            half_next   = in_half;
                            left_next   = {in_half, 1'b1};
                            rd_pos_next = start_s;
                            centre_next = fwd_reg ? (start_s + half_in_s) : (start_s - half_in_s);
                            clear_next  = 1'b1;
                            res_found_next = 1'b0;
                            res_idx_next   = '0;
                            res_val_next   = '0;
                            // A first window reaching past the data answers at once.
                            if (fwd_reg ? ((start_s + (half_in_s <<< 1)) >= count_s)
                                        : (((start_s - (half_in_s <<< 1)) < 0)
                                           || (start_s >= count_s))) begin
                                state_next = S_RES;
                            end else begin
                                state_next = S_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                rd_en_next  = 1'b1;
                rd_pos_next = fwd_reg ? (rd_pos_reg + STEP) : (rd_pos_reg - STEP);
                left_next   = left_reg - 1'b1;
                if (left_reg == WIN_W'(1)) begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE: state_next = S_CEN;
            S_CEN:    state_next = S_CMP;
            S_CMP:    state_next = S_DEC;
            S_DEC: begin
                if (peak) begin
                    res_found_next = 1'b1;
                    res_idx_next   = centre_reg[POS_W-1:0];
                    res_val_next   = cen_val_reg;
                    state_next     = S_RES;
                end else if (fwd_reg ? ((centre_reg + half_s) >= (count_s - 1))
                                     : ((centre_reg - half_s) <= 0)) begin
                    state_next = S_RES;
                end else begin
                    rd_en_next  = 1'b1;
                    rd_pos_next = fwd_reg ? (rd_pos_reg + STEP) : (rd_pos_reg - STEP);
                    centre_next = fwd_reg ? (centre_reg + STEP) : (centre_reg - STEP);
                    state_next  = S_SETTLE;
                end
            end
            S_RES: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            win_size_reg <= WIN_W'(5);
            fwd_reg      <= 1'b1;
            min_reg      <= 1'b0;
            rd_en_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_en_reg <= rd_en_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_WINDOW_SIZE: win_size_reg <= cfg_data;
                    CFG_FORWARD:     fwd_reg      <= cfg_data[0];
                    CFG_MINIMUM:     min_reg      <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        half_reg      <= half_next;
        left_reg      <= left_next;
        rd_pos_reg    <= rd_pos_next;
        centre_reg    <= centre_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        res_val_reg   <= res_val_next;
        if (state_reg == S_CEN) begin
            cen_val_reg <= cell_data[{1'b0, half_reg}];
        end
        if (out_load) begin
            m_found_reg <= res_found_reg;
            m_idx_reg   <= res_idx_reg;
            m_val_reg   <= res_val_reg;
        end
    end

    // Sample memory: one write port for appends, one registered read port for the walk.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= in_sample;
        end
        rd_data_reg <= mem[rd_pos_reg[ADDR_W-1:0]];
    end

    assign ctrl.shift    = rd_en_reg;
    assign ctrl.clear    = clear_next;
    assign ctrl.find_min = min_reg;
    assign ctrl.half     = half_reg;

    // Cell 0 takes the newest sample; older samples move one cell up per shift.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        logic [SW-1:0] prev_d;
        logic          prev_v;
        if (k == 0) begin : g_head
            assign prev_d = rd_data_reg;
            assign prev_v = 1'b1;
        end else begin : g_body
            assign prev_d = cell_data[k-1];
            assign prev_v = cell_valid[k-1];
        end
        wlps_cell #(
            .IDX (k),
            .SW  (SW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_data  (prev_d),
            .prev_valid (prev_v),
            .cen_val    (cen_val_reg),
            .data_o     (cell_data[k]),
            .valid_o    (cell_valid[k]),
            .fail_o     (cell_fail[k])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = DATA_W'({m_val_reg, m_idx_reg});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("sample count above store depth");

    a_shift_source: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en_reg |-> ($past(state_reg) == S_LOAD || $past(state_reg) == S_DEC))
        else $error("cell shift without a read issue");

    a_found_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RES && res_found_reg) |-> (centre_reg >= 0 && centre_reg < count_s))
        else $error("peak reported outside the stored data");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |=> (state_reg == S_DEC && !in_acc))
        else $error("compare not followed by decision");
`endif

endmodule
